// ----- design/indexed_list_insert_remove_core_macros.svh -----
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core_macros.svh
// Assertion macros used by the checker file of the indexed list core.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define ILIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ilir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg
// Sizes, codes and types of the indexed list core.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int DEPTH   = 16;
  localparam int WIDTH   = 32;

  // fixed port field widths
  localparam int ACT_W   = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef logic [WIDTH-1:0] entry_t;

  // per-cell update select, at most one bit set
  typedef struct packed {
    logic load;
    logic take_lower;
    logic take_upper;
  } cell_ctl_t;

endpackage

// ----- design/ilir_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds, loads the new value, or copies a neighbor.
// ----------------------------------------------------------------------------
module ilir_cell (
  input  logic               clk,
  input  ilir_pkg::cell_ctl_t ctl,
  input  ilir_pkg::entry_t   lower_q,
  input  ilir_pkg::entry_t   upper_q,
  input  ilir_pkg::entry_t   load_data,
  output ilir_pkg::entry_t   q
);
  import ilir_pkg::*;

  entry_t q_r;
  entry_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.load) begin
      q_nxt = load_data;
    end else if (ctl.take_lower) begin
      q_nxt = lower_q;
    end else if (ctl.take_upper) begin
      q_nxt = upper_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- design/ilir_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_ctrl
// Decodes one transaction, drives the cell selects, keeps the count and
// registers the result.
// ----------------------------------------------------------------------------
module ilir_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ilir_pkg::ACT_W-1:0]  in_action,
  input  logic [ilir_pkg::POS_W-1:0]  in_position,
  input  ilir_pkg::entry_t            cell_q [ilir_pkg::DEPTH],
  output ilir_pkg::cell_ctl_t         cell_ctl [ilir_pkg::DEPTH],
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ilir_pkg::VALUE_W-1:0] out_entry_out,
  output logic [ilir_pkg::STAT_W-1:0] out_status,
  output logic [ilir_pkg::COUNT_W-1:0] out_count,
  output logic                        out_empty_res
);
  import ilir_pkg::*;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  entry_t            entry_r;
  entry_t            entry_nxt;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;

  logic              accept;
  logic              do_ins;
  logic              do_rem;
  logic              full;
  logic              in_range;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  entry_t            rd_data;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign in_range = (pos_ext < cnt_ext);
  // only used when position is below the count
  assign rd_data  = cell_q[IDX_W'(in_position)];

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    entry_nxt  = '0;
    status_nxt = ST_OK;
    case (in_action)
      ACT_READ: begin
        if (in_range) begin
          entry_nxt = rd_data;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (in_range) begin
          entry_nxt = rd_data;
          do_rem    = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  // insert: slots above position up to the count take their lower neighbor
  // remove: slots from position up to count-2 take their upper neighbor
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].load       = accept && do_ins && (CMP_W'(i) == pos_ext);
      cell_ctl[i].take_lower = accept && do_ins && (CMP_W'(i) > pos_ext)
                               && (CMP_W'(i) <= cnt_ext);
      cell_ctl[i].take_upper = accept && do_rem && (CMP_W'(i) >= pos_ext)
                               && (CMP_W'(i + 1) < cnt_ext);
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (do_ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (do_rem) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r  <= entry_nxt;
      status_r <= status_nxt;
    end
  end

  // count only moves on accept, so it always matches the held result
  assign out_valid     = out_valid_r;
  assign out_entry_out = VALUE_W'(entry_r);
  assign out_status    = status_r;
  assign out_count     = COUNT_W'(count_r);
  assign out_empty_res = (count_r == '0);

endmodule

// ----- design/indexed_list_insert_remove_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Fixed-capacity ordered list built as a row of entry cells: read, insert
// or remove at an index, with count and empty flag on every result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | action, position, value
//  out_    | output    | out_valid/out_stall| entry_out, status, count, empty_res
//
//  One transaction per cycle when in_stall is low; the result appears
//  the cycle after acceptance. All cells shift in parallel in the accept
//  cycle; the output register is the only stage, and in_stall rises only
//  while a result waits under out_stall. Synchronous active-low reset clears
//  the count and the output valid; entry contents are not reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ilir_pkg::ACT_W-1:0]   in_action,
  input  logic [ilir_pkg::POS_W-1:0]   in_position,
  input  logic [ilir_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ilir_pkg::VALUE_W-1:0] out_entry_out,
  output logic [ilir_pkg::STAT_W-1:0]  out_status,
  output logic [ilir_pkg::COUNT_W-1:0] out_count,
  output logic                         out_empty_res
);
  import ilir_pkg::*;

  entry_t    cell_q   [DEPTH];
  cell_ctl_t cell_ctl [DEPTH];
  entry_t    load_data;

  assign load_data = WIDTH'(in_value);

  ilir_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .cell_q        (cell_q),
    .cell_ctl      (cell_ctl),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_entry_out (out_entry_out),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t lower_q;
    entry_t upper_q;

    if (i == 0) begin : g_first
      assign lower_q = '0;
    end else begin : g_lower
      assign lower_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_q = '0;
    end else begin : g_upper
      assign upper_q = cell_q[i+1];
    end

    ilir_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .lower_q   (lower_q),
      .upper_q   (upper_q),
      .load_data (load_data),
      .q         (cell_q[i])
    );
  end

endmodule

// ----- design/ilir_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_checker
// Port-level checks on the indexed list core, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_remove_core_macros.svh"

module ilir_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ilir_pkg::VALUE_W-1:0] out_entry_out,
  input logic [ilir_pkg::STAT_W-1:0]  out_status,
  input logic [ilir_pkg::COUNT_W-1:0] out_count,
  input logic                         out_empty_res
);
  import ilir_pkg::*;

  // a held result keeps its payload
  `ILIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_entry_out) && $stable(out_status) && $stable(out_count),
    "result changed while stalled")

  // input is only held back by a pending, stalled result
  `ILIR_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a waiting result")

  `ILIR_ASSERT_NOW(a_empty_flag, out_valid, out_empty_res == (out_count == '0),
    "empty flag disagrees with count")

  `ILIR_ASSERT_NOW(a_err_zero, out_valid && (out_status != ST_OK),
    out_entry_out == '0, "error result carries data")

  `ILIR_ASSERT_NOW(a_full_count, out_valid && (out_status == ST_FULL),
    out_count == COUNT_W'(DEPTH), "full status with a count below capacity")

endmodule

bind indexed_list_insert_remove_core ilir_checker u_ilir_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_entry_out (out_entry_out),
  .out_status    (out_status),
  .out_count     (out_count),
  .out_empty_res (out_empty_res)
);

// ----- sim/indexed_list_insert_remove_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core_tb
// Drives read, insert and remove transactions into the indexed list core,
// with a directed opening and then random traffic under several idle and
// stall mixes. A shadow list in a small scoreboard predicts every response,
// and each accepted response is compared field by field in order.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core_tb;
  import ilir_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 425;

  typedef struct {
    logic [VALUE_W-1:0] entry;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } list_result_t;

  class list_scoreboard;
    entry_t       cells [DEPTH];
    int           fill;
    list_result_t expected_q [$];
    int           mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted request to the shadow list and queue its response
    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] val);
      list_result_t r;
      int i;
      int p;
      p = int'(pos);
      r.entry = '0;
      r.status = ST_OK;
      case (act)
        ACT_READ: begin
          if (p < fill) r.entry = cells[p];
          else r.status = ST_RANGE;
        end
        ACT_INSERT: begin
          // full takes priority over the position check
          if (fill >= DEPTH) r.status = ST_FULL;
          else if (p > fill) r.status = ST_RANGE;
          else begin
            for (i = fill; i > p; i--) cells[i] = cells[i-1];
            cells[p] = val[WIDTH-1:0];
            fill++;
          end
        end
        ACT_REMOVE: begin
          if (p < fill) begin
            r.entry = cells[p];
            for (i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: r.status = ST_RANGE;
      endcase
      r.count = fill[COUNT_W-1:0];
      r.empty = (fill == 0);
      expected_q.push_back(r);
    endfunction

    function void check_response(logic [VALUE_W-1:0] entry, logic [STAT_W-1:0] status,
                                 logic [COUNT_W-1:0] count, logic empty);
      list_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: entry=%h status=%0d count=%0d empty=%0b",
                   entry, status, count, empty);
        return;
      end
      e = expected_q.pop_front();
      if (entry !== e.entry || status !== e.status || count !== e.count ||
          empty !== e.empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp entry=%h status=%0d count=%0d empty=%0b,",
                   e.entry, e.status, e.count, e.empty,
                   " got entry=%h status=%0d count=%0d empty=%0b",
                   entry, status, count, empty);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   in_action = ACT_READ;
  logic [POS_W-1:0]   in_position = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] out_entry_out;
  logic [STAT_W-1:0]  out_status;
  logic [COUNT_W-1:0] out_count;
  logic               out_empty_res;

  list_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int gen_count = 0;   // list length as the generator sees it
  bit filling = 1'b1;

  indexed_list_insert_remove_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_entry_out (out_entry_out),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // check before noting: a response never belongs to the same-edge request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_response(out_entry_out, out_status, out_count, out_empty_res);
      if (in_valid && !in_stall)
        sb.note_request(in_action, in_position, in_value);
    end
  end

  task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [VALUE_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    if (act == ACT_INSERT && gen_count < DEPTH && int'(pos) <= gen_count)
      gen_count++;
    else if (act == ACT_REMOVE && int'(pos) < gen_count)
      gen_count--;
  endtask

  task automatic send_random();
    int r;
    int lim;
    logic [ACT_W-1:0]   act;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    if (gen_count == DEPTH) filling = 1'b0;
    else if (gen_count == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 4) act = ACT_UNUSED;
    else if (r < 34) act = ACT_READ;
    else if (r < 80) act = filling ? ACT_INSERT : ACT_REMOVE;
    else act = filling ? ACT_REMOVE : ACT_INSERT;
    lim = (act == ACT_INSERT) ? gen_count : gen_count - 1;
    if (lim < 0) lim = 0;
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, lim));
    else pos = POS_W'($urandom_range(0, 31));
    r = $urandom_range(0, 19);
    if (r == 0) val = '0;
    else if (r == 1) val = '1;
    else val = $urandom();
    send_item(act, pos, val);
  endtask

  // hold off the sender until every queued response has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list and unused action
    send_item(ACT_READ, 5'd0, 32'h1111_1111);
    send_item(ACT_REMOVE, 5'd0, 32'h0);
    send_item(ACT_INSERT, 5'd1, 32'hdead_beef);
    send_item(ACT_UNUSED, 5'd31, '1);
    // fill to capacity: front, append and middle inserts
    send_item(ACT_INSERT, 5'd0, '1);
    send_item(ACT_INSERT, 5'd0, '0);
    send_item(ACT_INSERT, 5'd2, 32'h8000_0001);
    for (i = 3; i < DEPTH; i++)
      send_item(ACT_INSERT, POS_W'($urandom_range(0, i)), $urandom());
    // full wins over a bad position, then reads and removes at the ends and past the end
    send_item(ACT_INSERT, 5'd0, 32'h5555_5555);
    send_item(ACT_INSERT, 5'd31, 32'haaaa_aaaa);
    send_item(ACT_READ, 5'd15, '0);
    send_item(ACT_READ, 5'd16, '0);
    send_item(ACT_REMOVE, 5'd15, '0);
    send_item(ACT_REMOVE, 5'd0, '0);
    send_item(ACT_REMOVE, 5'd14, '0);
    drain();

    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- indexed_list_insert_remove_core.f -----
+incdir+design
design/ilir_pkg.sv
design/ilir_cell.sv
design/ilir_ctrl.sv
design/indexed_list_insert_remove_core.sv
design/ilir_checker.sv
sim/indexed_list_insert_remove_core_tb.sv
